// File: rtl/psm_pkg.sv
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types, codes and defaults of the pair-sum multiset block.
// ----------------------------------------------------------------------------
package psm_pkg;

    // Default number of distinct keys the table holds
    localparam int TABLE_ENTRIES_DEF = 64;

    // Operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    // Initial and saturation values of an occurrence count
    localparam logic [1:0] COUNT_ONE = 2'd1;
    localparam logic [1:0] COUNT_MAX = 2'd2;

    // Input item
    typedef struct packed {
        logic               opcode;
        logic signed [31:0] operand;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic pair_found;
        logic table_full;
    } out_item_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_CMP,
        ST_ADD_NEW,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_POST
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // latch the item, clear result, rewind both scan indices
        logic rd;        // read key and count memories at the scan indices
        logic j_next;    // advance inner index
        logic i_next;    // advance outer index, restart inner index on it
        logic bump;      // raise the count of the slot under the inner index
        logic insert;    // write the operand into the next free slot
        logic set_found; // mark a pair found
        logic set_full;  // mark a dropped add
        logic post;      // move the result into the output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;     // no keys stored
        logic full;      // every slot in use
        logic i_last;    // outer index on the last stored slot
        logic j_last;    // inner index on the last stored slot
        logic key_hit;   // key read at inner index equals the operand
        logic pair_hit;  // keys read at both indices form a valid pair
        logic out_busy;  // output register holds a result not yet taken
    } status_t;

endpackage

// File: rtl/pair_sum_multiset.sv
// ----------------------------------------------------------------------------
// pair_sum_multiset
// Bounded multiset of signed 32-bit numbers with pair-sum queries.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries in_item: opcode OP_ADD stores the
// operand (a new key, or one more occurrence of a stored key, counted up to
// two), opcode OP_FIND asks whether two stored elements sum to the operand.
// Output channel out_valid/out_ready carries one out_item per input item:
// pair_found for a find, table_full for an add of a new key to a full table.
// One item is worked on at a time; in_ready is high only while idle.
// With n keys stored, an add scans the key memory slot by slot, a read state
// then a compare state per slot, until the key is found or the slots run out. A find
// tries every pair of slots i <= j, reading both keys of a pair at once through the
// two-read-port key memory, and posts sooner when a pair turns up early. The next
// input transfer is taken once the result is posted and the controller is idle again.
// A posted result sits in the output register; the next item is taken while
// it waits, and a further result is held back until the first is taken.
// Reset empties the table by clearing the fill count; no clearing pass runs.
// ----------------------------------------------------------------------------
module pair_sum_multiset
#(
    parameter int TABLE_ENTRIES = psm_pkg::TABLE_ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  psm_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output psm_pkg::out_item_t  out_item
);

    psm_pkg::cmd_t    cmd;
    psm_pkg::status_t status;

    // Sequence the scan
    psm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_opcode (in_item.opcode),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Store keys and evaluate pairs
    psm_datapath
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

// File: rtl/psm_ctrl.sv
// ----------------------------------------------------------------------------
// psm_ctrl
// Sequencer of the pair-sum multiset: accepts an item, steps the datapath
// through the key scan and posts one result per item.
// ----------------------------------------------------------------------------
module psm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_opcode,
    output logic              in_ready,
    input  psm_pkg::status_t  status,
    output psm_pkg::cmd_t     cmd
);

    psm_pkg::state_t state_reg;
    psm_pkg::state_t state_next;
    logic            accept;

    assign accept = in_valid && (state_reg == psm_pkg::ST_IDLE);

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.empty)
                    begin
                        state_next = (in_opcode == psm_pkg::OP_ADD) ? psm_pkg::ST_ADD_NEW
                                                                     : psm_pkg::ST_POST;
                    end
                    else
                    begin
                        state_next = (in_opcode == psm_pkg::OP_ADD) ? psm_pkg::ST_ADD_RD
                                                                     : psm_pkg::ST_FIND_RD;
                    end
                end
            end
            psm_pkg::ST_ADD_RD:
            begin
                state_next = psm_pkg::ST_ADD_CMP;
            end
            psm_pkg::ST_ADD_CMP:
            begin
                if (status.key_hit)
                begin
                    state_next = psm_pkg::ST_POST;
                end
                else if (status.j_last)
                begin
                    state_next = psm_pkg::ST_ADD_NEW;
                end
                else
                begin
                    state_next = psm_pkg::ST_ADD_RD;
                end
            end
            psm_pkg::ST_ADD_NEW:
            begin
                state_next = psm_pkg::ST_POST;
            end
            psm_pkg::ST_FIND_RD:
            begin
                state_next = psm_pkg::ST_FIND_CMP;
            end
            psm_pkg::ST_FIND_CMP:
            begin
                if (status.pair_hit || (status.j_last && status.i_last))
                begin
                    state_next = psm_pkg::ST_POST;
                end
                else
                begin
                    state_next = psm_pkg::ST_FIND_RD;
                end
            end
            psm_pkg::ST_POST:
            begin
                if (!status.out_busy)
                begin
                    state_next = psm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psm_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            psm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = accept;
            end
            psm_pkg::ST_ADD_RD:
            begin
                cmd.rd = 1'b1;
            end
            psm_pkg::ST_ADD_CMP:
            begin
                if (status.key_hit)
                begin
                    cmd.bump = 1'b1;
                end
                else if (!status.j_last)
                begin
                    cmd.j_next = 1'b1;
                end
            end
            psm_pkg::ST_ADD_NEW:
            begin
                cmd.insert   = !status.full;
                cmd.set_full = status.full;
            end
            psm_pkg::ST_FIND_RD:
            begin
                cmd.rd = 1'b1;
            end
            psm_pkg::ST_FIND_CMP:
            begin
                if (status.pair_hit)
                begin
                    cmd.set_found = 1'b1;
                end
                else if (!status.j_last)
                begin
                    cmd.j_next = 1'b1;
                end
                else if (!status.i_last)
                begin
                    cmd.i_next = 1'b1;
                end
            end
            psm_pkg::ST_POST:
            begin
                cmd.post = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/psm_datapath.sv
// ----------------------------------------------------------------------------
// psm_datapath
// Key and count memories, scan indices, pair adder and output register of
// the pair-sum multiset.
// ----------------------------------------------------------------------------
module psm_datapath
#(
    parameter int TABLE_ENTRIES = psm_pkg::TABLE_ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  psm_pkg::in_item_t   in_item,
    input  psm_pkg::cmd_t       cmd,
    output psm_pkg::status_t    status,
    input  logic                out_ready,
    output logic                out_valid,
    output psm_pkg::out_item_t  out_item
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // Memories
    logic signed [31:0] key_mem [TABLE_ENTRIES];
    logic [1:0]         cnt_mem [TABLE_ENTRIES];

    // Registers
    psm_pkg::in_item_t  item_reg;
    logic [CNT_W-1:0]   used_reg,      used_next;
    logic [IDX_W-1:0]   i_reg,         i_next;
    logic [IDX_W-1:0]   j_reg,         j_next;
    logic               found_reg,     found_next;
    logic               full_reg,      full_next;
    logic               out_valid_reg, out_valid_next;
    psm_pkg::out_item_t out_item_reg;
    logic signed [31:0] key_a_reg;
    logic signed [31:0] key_b_reg;
    logic [1:0]         cnt_b_reg;
    logic               same_reg;

    logic [CNT_W-1:0]   last_idx;
    logic signed [32:0] pair_sum;
    logic [1:0]         cnt_bumped;

    // Latch the item on acceptance
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
    end

    // Write and read the memories
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            key_mem[used_reg[IDX_W-1:0]] <= item_reg.operand;
            cnt_mem[used_reg[IDX_W-1:0]] <= psm_pkg::COUNT_ONE;
        end
        else if (cmd.bump)
        begin
            cnt_mem[j_reg] <= cnt_bumped;
        end
        if (cmd.rd)
        begin
            key_a_reg <= key_mem[i_reg];
            key_b_reg <= key_mem[j_reg];
            cnt_b_reg <= cnt_mem[j_reg];
            same_reg  <= (i_reg == j_reg);
        end
    end

    // Saturate the count
    assign cnt_bumped = (cnt_b_reg == psm_pkg::COUNT_MAX) ? psm_pkg::COUNT_MAX
                                                          : cnt_b_reg + 2'd1;

    // Step the scan indices and the fill count
    always_comb
    begin
        used_next = used_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        if (cmd.load)
        begin
            i_next = '0;
            j_next = '0;
        end
        else if (cmd.i_next)
        begin
            i_next = i_reg + 1'b1;
            j_next = i_reg + 1'b1;
        end
        else if (cmd.j_next)
        begin
            j_next = j_reg + 1'b1;
        end
        if (cmd.insert)
        begin
            used_next = used_reg + 1'b1;
        end
    end

    // Collect the result flags
    always_comb
    begin
        found_next = found_reg;
        full_next  = full_reg;
        if (cmd.load)
        begin
            found_next = 1'b0;
            full_next  = 1'b0;
        end
        else
        begin
            if (cmd.set_found)
            begin
                found_next = 1'b1;
            end
            if (cmd.set_full)
            begin
                full_next = 1'b1;
            end
        end
    end

    // Hold the output transfer until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.post)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        found_reg <= found_next;
        full_reg  <= full_next;
        if (cmd.post)
        begin
            out_item_reg.pair_found <= found_reg;
            out_item_reg.table_full <= full_reg;
        end
    end

    // Add the two keys at full width; a slot pairs with itself only when counted twice
    assign pair_sum = {key_a_reg[31], key_a_reg} + {key_b_reg[31], key_b_reg};
    assign last_idx = used_reg - 1'b1;

    always_comb
    begin
        status.empty    = (used_reg == '0);
        status.full     = (used_reg == CNT_W'(TABLE_ENTRIES));
        status.i_last   = (CNT_W'(i_reg) == last_idx);
        status.j_last   = (CNT_W'(j_reg) == last_idx);
        status.key_hit  = (key_b_reg == item_reg.operand);
        status.pair_hit = (pair_sum == {item_reg.operand[31], item_reg.operand})
                          && (!same_reg || (cnt_b_reg == psm_pkg::COUNT_MAX));
        status.out_busy = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
